FILE: src/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes for the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_DEL_FAIL  = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_LEN,
    S_SCAN,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture request, start modulo
    logic mod_step;  // one restoring-subtract step
    logic len_rd;    // latch bucket length
    logic idx_init;  // set walk index for the chosen operation
    logic rd;        // read entry at walk index
    logic cmp;       // compare read data with key
    logic idx_inc;
    logic idx_dec;
    logic wr;        // write shifted entry
    logic finish;    // write length and build result
    logic out_load;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic mod_done;
    logic is_insert;
    logic is_delete;
    logic is_search;
    logic full;
    logic scan_end;  // walk index reached length
    logic match;
    logic shift_end;
    logic out_busy;
  } stat_t;

endpackage

FILE: src/cht_ctrl.sv
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer: modulo, length fetch, chain walk and shift, result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl
  import cht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  stat_t stat,
  output logic  in_rdy,
  output ctrl_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_fire) state_next = S_MOD;
      S_MOD:      if (stat.mod_done) state_next = S_LEN;
      S_LEN:      state_next = S_SCAN;
      S_SCAN: begin
        priority if (stat.is_insert) begin
          state_next = stat.full ? S_DONE : S_SHIFT_RD;
        end else if (!stat.is_delete && !stat.is_search) begin
          state_next = S_DONE;
        end else if (stat.scan_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        priority if (!stat.match) state_next = S_SCAN;
        else if (stat.is_delete) state_next = S_SHIFT_RD;
        else state_next = S_DONE;
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = stat.shift_end ? S_DONE : S_SHIFT_RD;
      S_DONE:     state_next = S_OUT;
      S_OUT:      if (!stat.out_busy) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_rdy = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_rdy = 1'b1;
        ctrl.load = in_fire;
      end
      S_MOD:  ctrl.mod_step = 1'b1;
      S_LEN: begin
        ctrl.len_rd = 1'b1;
        ctrl.idx_init = 1'b1;
      end
      S_SCAN: ctrl.rd = 1'b1;
      S_SCAN_CMP: begin
        ctrl.cmp = 1'b1;
        ctrl.idx_inc = !stat.match;
      end
      S_SHIFT_RD: ctrl.rd = 1'b1;
      S_SHIFT_WR: begin
        ctrl.wr = 1'b1;
        ctrl.idx_inc = stat.is_delete;
        ctrl.idx_dec = stat.is_insert;
      end
      S_DONE: ctrl.finish = 1'b1;
      S_OUT:  ctrl.out_load = !stat.out_busy;
      default: ;
    endcase
  end

endmodule

FILE: src/cht_dp.sv
// ----------------------------------------------------------------------------
// cht_dp
// Datapath: bit-serial modulo, key memory, lengths, walk index, output register.
// ----------------------------------------------------------------------------
module cht_dp
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 16,
  parameter int CHAIN_DEPTH = 8,
  parameter int KEY_BITS    = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            opcode,
  input  logic [30:0]           key,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata,
  input  ctrl_t                 ctrl,
  output stat_t                 stat,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            status,
  output logic [3:0]            bucket,
  output logic [2:0]            position
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CW = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int LW = $clog2(CHAIN_DEPTH + 1);
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int RW = NW + 1;
  localparam int KCW = $clog2(KEY_BITS + 1);
  // Each bucket owns a power-of-two slot so the address is a plain concatenation.
  localparam int AW = BW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [NW-1:0] NMAX = NW'(MAX_BUCKETS);
  localparam logic [LW-1:0] LMAX = LW'(CHAIN_DEPTH);

  logic [4:0]          num_buckets;
  logic [1:0]          op;
  logic [KEY_BITS-1:0] kreg;
  logic [KEY_BITS-1:0] kshift;
  logic [RW-1:0]       rem;
  logic [KCW-1:0]      kcnt;
  logic [NW-1:0]       nuse;
  logic [BW-1:0]       bidx;
  logic [LW-1:0]       len;
  logic [LW-1:0]       idx;
  logic [LW-1:0]       lengths [MAX_BUCKETS];
  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [KEY_BITS-1:0] rdata;
  logic                found;
  logic [LW-1:0]       fpos;
  logic [2:0]          res_status;
  logic [RW-1:0]       rem_sh;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [LW-1:0]       src_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buckets <= 5'd16;
    end else if (cfg_we) begin
      num_buckets <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (num_buckets == 5'd0) nuse = NW'(1);
    else if (32'(num_buckets) > MAX_BUCKETS) nuse = NMAX;
    else nuse = NW'(num_buckets);
  end

  assign rem_sh = {rem[RW-2:0], kshift[KEY_BITS-1]};
  assign bidx = BW'(rem);

  // Restoring modulo, one key bit per cycle.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op <= opcode;
      kreg <= KEY_BITS'(key);
      kshift <= KEY_BITS'(key);
      rem <= '0;
      kcnt <= '0;
    end else if (ctrl.mod_step) begin
      kshift <= kshift << 1;
      kcnt <= kcnt + KCW'(1);
      rem <= (rem_sh >= RW'(nuse)) ? rem_sh - RW'(nuse) : rem_sh;
    end
  end

  assign stat.mod_done = (kcnt == KCW'(KEY_BITS - 1)) && ctrl.mod_step;
  assign stat.is_insert = (op == OP_INSERT);
  assign stat.is_delete = (op == OP_DELETE);
  assign stat.is_search = (op == OP_SEARCH);
  assign stat.full = (len >= LMAX);
  assign stat.scan_end = (idx >= len);
  assign stat.match = (rdata == kreg);
  assign stat.out_busy = out_valid && !out_ready;
  // Insert walks idx from len down to 0; delete walks up from p until idx + 2 >= len.
  assign stat.shift_end = stat.is_insert ? (idx == LW'(0)) : (idx + LW'(2) >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BUCKETS; i++) lengths[i] <= '0;
    end else if (ctrl.finish) begin
      if (stat.is_insert && !stat.full) lengths[bidx] <= len + LW'(1);
      else if (stat.is_delete && found) lengths[bidx] <= len - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.len_rd) len <= lengths[bidx];
  end

  always_ff @(posedge clk) begin
    if (ctrl.idx_init) begin
      idx <= (op == OP_INSERT) ? lengths[bidx] : '0;
    end else if (ctrl.idx_inc) begin
      idx <= idx + LW'(1);
    end else if (ctrl.idx_dec) begin
      idx <= idx - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      found <= 1'b0;
      fpos <= '0;
    end else if (ctrl.cmp && stat.match) begin
      found <= 1'b1;
      fpos <= idx;
    end
  end

  // Insert reads idx-1 and writes idx (head gets key); delete reads idx+1, writes idx.
  always_comb begin
    if (stat.is_insert) src_idx = idx - LW'(1);
    else if (ctrl.cmp || !found) src_idx = idx;
    else src_idx = idx + LW'(1);
  end

  assign rd_addr = AW'({bidx, CW'(src_idx)} );
  assign wr_addr = AW'({bidx, CW'(idx)});

  always_ff @(posedge clk) begin
    if (ctrl.rd) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[wr_addr] <= (stat.is_insert && idx == LW'(0)) ? kreg : rdata;
    end
  end

  always_comb begin
    unique case (op)
      OP_INSERT: res_status = stat.full ? ST_FULL : ST_INSERTED;
      OP_DELETE: res_status = found ? ST_DELETED : ST_DEL_FAIL;
      OP_SEARCH: res_status = found ? ST_FOUND : ST_NOT_FOUND;
      default:   res_status = ST_NOT_FOUND;
    endcase
  end

  logic [2:0] st_hold;
  logic [2:0] pos_hold;
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      st_hold <= res_status;
      pos_hold <= (found && op != OP_INSERT) ? 3'(fpos) : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      status <= st_hold;
      bucket <= 4'(bidx);
      position <= pos_hold;
    end
  end

endmodule

FILE: src/chained_hash_table_core.sv
// ----------------------------------------------------------------------------
// chained_hash_table_core
// Separate-chaining hash table with insert, delete and search.
// ----------------------------------------------------------------------------
// A request beat (opcode, key) is taken on in_valid and in_ready; one result
// beat (status, bucket, position) leaves on out_valid and out_ready.
// num_buckets is written through cfg_we and cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this. One request is
// in flight at a time. The bucket comes from a bit-serial restoring modulo,
// one key bit per cycle; the chain is then walked and shifted through the
// key memory, with reads and writes in separate states. in_ready returns in
// the cycle after the result is loaded.
// Reset clears every chain length and sets num_buckets to 16; key memory
// contents are not cleared. A stalled result is held in the output
// register; one more request is still taken, and its result then waits in
// the controller, with no further request taken, until the held beat has
// been taken.
// ----------------------------------------------------------------------------
module chained_hash_table_core
  import cht_pkg::*;
#(
  parameter int MAX_BUCKETS = 16,
  parameter int CHAIN_DEPTH = 8,
  parameter int KEY_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [30:0] key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  bucket,
  output logic [2:0]  position,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  ctrl_t ctrl;
  stat_t stat;

  cht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_valid && in_ready),
    .stat    (stat),
    .in_rdy  (in_ready),
    .ctrl    (ctrl)
  );

  cht_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .opcode    (opcode),
    .key       (key),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .bucket    (bucket),
    .position  (position)
  );

endmodule
